### rtl/qpe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qpe_pkg
// Shared types, constants and helper functions of the quoted-printable encoder.
// ----------------------------------------------------------------------------
package qpe_pkg;

  localparam logic [7:0] LINE_LIMIT_RESET = 8'd75;

  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_SP    = 8'h20;
  localparam logic [7:0] CHR_EQ    = 8'h3D;
  localparam logic [7:0] CHR_DEL   = 8'h7F;
  localparam logic [7:0] UTF8_TWO  = 8'hDF;
  localparam logic [7:0] UTF8_THR  = 8'hEF;
  localparam logic [7:0] UTF8_FOUR = 8'hF4;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // back-end step codes within one token
  localparam logic [2:0] STEP_BRK_EQ = 3'd0;
  localparam logic [2:0] STEP_BRK_CR = 3'd1;
  localparam logic [2:0] STEP_BRK_LF = 3'd2;
  localparam logic [2:0] STEP_LEAD   = 3'd3;
  localparam logic [2:0] STEP_HI     = 3'd4;
  localparam logic [2:0] STEP_LO     = 3'd5;

  typedef struct packed {
    logic       vld;
    logic       pair;
    logic       brk;
    logic       esc;
    logic [7:0] data;
  } tok_t;

  typedef struct packed {
    tok_t a;
    tok_t b;
    logic last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic       brk;
    logic       esc;
    logic [8:0] lp_next;
  } enc_t;

  function automatic enc_t qpe_encode(input logic [7:0] c, input logic has_next,
                                      input logic [7:0] nxt, input logic [8:0] lp,
                                      input logic [7:0] lim);
    enc_t        r;
    logic [10:0] lp3;
    logic [10:0] lp1;
    logic [10:0] need;
    logic [3:0]  margin;
    r.esc = (c < CHR_SP) || (c == CHR_DEL) || c[7] || (c == CHR_EQ)
            || ((c == CHR_SP) && has_next && (nxt == CHR_CR));
    lp3 = {2'b00, lp} + 11'd3;
    lp1 = {2'b00, lp} + 11'd1;
    if (c <= CHR_DEL) begin
      margin = 4'd0;
    end else if (c <= UTF8_TWO) begin
      margin = 4'd3;
    end else if (c <= UTF8_THR) begin
      margin = 4'd6;
    end else if (c <= UTF8_FOUR) begin
      margin = 4'd9;
    end else begin
      margin = 4'd0;
    end
    need = lp3 + {7'd0, margin};
    r.brk = r.esc ? (need > {3'd0, lim}) : (lp1 > {3'd0, lim});
    if (r.brk) begin
      r.lp_next = r.esc ? 9'd3 : 9'd1;
    end else begin
      r.lp_next = r.esc ? lp3[8:0] : lp1[8:0];
    end
    return r;
  endfunction

  function automatic logic [7:0] qpe_hex(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = 8'h30 + {4'd0, d};
    end else begin
      r = 8'h37 + {4'd0, d};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/qpe_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qpe_if
// Valid/ready channel interfaces: raw bytes in, encoded bytes out, line limit.
// ----------------------------------------------------------------------------
interface qpe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface qpe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       message_end;
  modport source (output valid, output out_byte, output run_last, output message_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input message_end,
                  output ready);
endinterface

interface qpe_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/qpe_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qpe_front
// Accepts raw bytes, keeps the lookahead byte and line position, classifies
// each byte into output tokens and queues at most one job per request.
// ----------------------------------------------------------------------------
module qpe_front (
  input  logic             clk,
  input  logic             rst,
  qpe_in_if.sink           raw,
  qpe_cfg_if.sink          setup,
  input  qpe_pkg::qstat_t  qstat,
  output logic             push,
  output qpe_pkg::job_t    push_job
);
  import qpe_pkg::*;

  logic [7:0] line_limit;
  logic [7:0] held_byte;
  logic       held_valid;
  logic [8:0] line_position;

  logic [7:0] held_byte_next;
  logic       held_valid_next;
  logic [8:0] line_position_next;

  logic       acc;
  logic       hv1;
  logic [7:0] held1;
  logic [8:0] lp1;
  enc_t       e1;
  enc_t       e2;
  tok_t       ta;
  tok_t       tb;

  assign setup.ready = 1'b1;
  assign raw.ready   = !qstat.full;
  assign acc         = raw.valid && raw.ready;

  assign e1 = qpe_encode(held_byte, 1'b1, raw.in_byte, line_position, line_limit);
  assign e2 = qpe_encode(held1, 1'b0, 8'd0, lp1, line_limit);

  always_comb begin
    ta    = '0;
    tb    = '0;
    hv1   = 1'b1;
    held1 = raw.in_byte;
    lp1   = line_position;
    if (held_valid) begin
      if ((held_byte == CHR_CR) && (raw.in_byte == CHR_LF)) begin
        ta.vld  = 1'b1;
        ta.pair = 1'b1;
        hv1     = 1'b0;
        held1   = 8'd0;
        lp1     = 9'd0;
      end else begin
        ta.vld  = 1'b1;
        ta.brk  = e1.brk;
        ta.esc  = e1.esc;
        ta.data = held_byte;
        lp1     = e1.lp_next;
      end
    end
    held_byte_next     = held1;
    held_valid_next    = hv1;
    line_position_next = lp1;
    if (raw.in_last) begin
      if (hv1) begin
        tb.vld  = 1'b1;
        tb.brk  = e2.brk;
        tb.esc  = e2.esc;
        tb.data = held1;
      end
      held_byte_next     = 8'd0;
      held_valid_next    = 1'b0;
      line_position_next = 9'd0;
    end
    // keep the first slot filled
    if (!ta.vld) begin
      push_job.a = tb;
      push_job.b = '0;
    end else begin
      push_job.a = ta;
      push_job.b = tb;
    end
    push_job.last = raw.in_last;
    push          = acc && (ta.vld || tb.vld);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit    <= LINE_LIMIT_RESET;
      held_byte     <= 8'd0;
      held_valid    <= 1'b0;
      line_position <= 9'd0;
    end else begin
      if (setup.valid && setup.ready) begin
        line_limit <= setup.data;
      end
      if (acc) begin
        held_byte     <= held_byte_next;
        held_valid    <= held_valid_next;
        line_position <= line_position_next;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/qpe_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qpe_queue
// Small job queue between the classifying front and the expanding back.
// ----------------------------------------------------------------------------
module qpe_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  qpe_pkg::job_t    push_job,
  input  logic             pop,
  output qpe_pkg::job_t    head,
  output qpe_pkg::qstat_t  qstat
);
  import qpe_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign qstat.full  = (count == QCNT_W'(QDEPTH));
  assign qstat.empty = (count == '0);
  assign head        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/qpe_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qpe_back
// Expands the job at the queue head into encoded bytes, one per cycle while
// the output accepts them, into an output register.
// ----------------------------------------------------------------------------
module qpe_back (
  input  logic             clk,
  input  logic             rst,
  input  qpe_pkg::job_t    head,
  input  qpe_pkg::qstat_t  qstat,
  output logic             pop,
  qpe_out_if.source        coded
);
  import qpe_pkg::*;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       run_last;
  logic       message_end;
  logic       sel;
  logic       fresh;
  logic [2:0] step;

  tok_t       cur;
  logic [2:0] start;
  logic [2:0] stop;
  logic [2:0] eff;
  logic [7:0] byte_next;
  logic       fire;
  logic       tok_end;
  logic       job_end;

  assign coded.valid       = out_valid;
  assign coded.out_byte    = out_byte;
  assign coded.run_last    = run_last;
  assign coded.message_end = message_end;

  always_comb begin
    cur   = sel ? head.b : head.a;
    start = cur.pair ? STEP_HI : (cur.brk ? STEP_BRK_EQ : STEP_LEAD);
    stop  = (cur.pair || cur.esc) ? STEP_LO : STEP_LEAD;
    eff   = fresh ? start : step;
    case (eff)
      STEP_BRK_EQ: byte_next = CHR_EQ;
      STEP_BRK_CR: byte_next = CHR_CR;
      STEP_BRK_LF: byte_next = CHR_LF;
      STEP_LEAD:   byte_next = cur.esc ? CHR_EQ : cur.data;
      STEP_HI:     byte_next = cur.pair ? CHR_CR : qpe_hex(cur.data[7:4]);
      STEP_LO:     byte_next = cur.pair ? CHR_LF : qpe_hex(cur.data[3:0]);
      default:     byte_next = cur.data;
    endcase
    fire    = !qstat.empty && (!out_valid || coded.ready);
    tok_end = (eff == stop);
    job_end = tok_end && (sel || !head.b.vld);
    pop     = fire && job_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
      fresh     <= 1'b1;
      step      <= STEP_BRK_EQ;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
        if (tok_end) begin
          fresh <= 1'b1;
          sel   <= !job_end;
        end else begin
          fresh <= 1'b0;
          step  <= eff + 3'd1;
        end
      end else if (coded.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte    <= byte_next;
      run_last    <= job_end;
      message_end <= job_end && head.last;
    end
  end

endmodule
`default_nettype wire

### rtl/quoted_printable_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quoted_printable_encoder
// Streaming quoted-printable encoder with one byte of lookahead and soft
// line breaks against a programmable line limit.
// ----------------------------------------------------------------------------
//  channel  dir  payload                          request completes on
//  raw      in   in_byte[7:0], in_last            valid & ready
//  coded    out  out_byte[7:0], run_last,         valid & ready
//                message_end
//  setup    in   data[7:0] (line_limit)           valid & ready (ready tied high)
//
// the front takes one request per cycle while the four-entry job queue has room
// the back emits one encoded byte per cycle while a job waits and the output takes it;
// a request yields 0 to 12 bytes (1 literal, 3 escape, plus 3 per soft break)
// the first result of a request is registered in the job queue, then in the output register
// synchronous reset restores line limit 75, empty lookahead and line position zero
// a stalled output holds its byte while the front keeps filling the queue
// ----------------------------------------------------------------------------
module quoted_printable_encoder (
  input  logic      clk,
  input  logic      rst,
  qpe_in_if.sink    raw,
  qpe_out_if.source coded,
  qpe_cfg_if.sink   setup
);
  import qpe_pkg::*;

  logic   push;
  logic   pop;
  job_t   push_job;
  job_t   head;
  qstat_t qstat;

  qpe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .raw      (raw),
    .setup    (setup),
    .qstat    (qstat),
    .push     (push),
    .push_job (push_job)
  );

  qpe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  qpe_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .qstat (qstat),
    .pop   (pop),
    .coded (coded)
  );

`ifndef SYNTHESIS
  a_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    coded.valid && coded.message_end |-> coded.run_last)
    else $error("message end without run last");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    qstat.full |-> !push)
    else $error("push into full job queue");

  a_head_has_token: assert property (@(posedge clk) disable iff (rst)
    !qstat.empty |-> head.a.vld)
    else $error("queued job without first token");

  a_pop_needs_job: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("pop from empty job queue");
`endif

endmodule
`default_nettype wire
